/* sv/assert_macros.svh */
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define VTN_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vtn assertion failed");

// Clocked assertion that also holds during reset.
`define VTN_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("vtn assertion failed");

`endif

/* sv/vtn_pkg.sv */
// Types and constants shared by the vertex transform files.
`default_nettype none
package vtn_pkg;

   localparam int NUM_CSR = 6;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 64;
   localparam int REQ_W   = 288;
   localparam int RSP_W   = 248;
   localparam int NRM_W   = 18;
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   localparam logic [CSR_DW-1:0] CSR_RESET [NUM_CSR] = '{
      64'd65536, 64'd0, 64'd281474976710656, 64'd0, 64'd0, 64'd65536
   };

   // one transformed vertex, front to back
   typedef struct packed {
      logic [2:0][31:0] col;
      logic [2:0][31:0] nrm;
      logic [2:0][31:0] pos;
   } xfm_type;

endpackage
`default_nettype wire

/* sv/vtn_front.sv */
// Front: config registers, matrix products, rounding, sums and saturation.
`default_nettype none
module vtn_front
   import vtn_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wen,
   input  wire logic [CSR_AW-1:0] csr_addr,
   input  wire logic [CSR_DW-1:0] csr_wdata,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_W-1:0]  req_tdata,
   input  wire logic              q_full,
   output logic                   q_push,
   output xfm_type                q_data
);

   logic [CSR_DW-1:0] coef_ff [NUM_CSR];

   logic signed [63:0] prp_ff [3][3];
   logic signed [63:0] prn_ff [3][3];
   logic signed [63:0] prp_in [3][3];
   logic signed [63:0] prn_in [3][3];
   logic signed [31:0] tr_ff  [3];
   logic [2:0][31:0]   col_ff;
   logic               f1_vld_ff;
   logic               f2_vld_ff;
   xfm_type            f2_ff;
   xfm_type            f2_in;
   logic               ce;

   function automatic logic signed [31:0] coef_of(input logic [CSR_DW-1:0] r, input logic hi);
      return hi ? $signed(r[63:32]) : $signed(r[31:0]);
   endfunction

   // Q32.32 to Q16.16, ties toward +inf
   function automatic logic signed [47:0] rnd_q16(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd32768;
      return $signed(t[63:16]);
   endfunction

   function automatic logic [31:0] sat32(input logic signed [49:0] s);
      logic [31:0] r;
      if (s > 50'sd2147483647) r = 32'h7fff_ffff;
      else if (s < -50'sd2147483648) r = 32'h8000_0000;
      else r = s[31:0];
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CSR; i++) coef_ff[i] <= CSR_RESET[i];
      end else if (csr_wen && (csr_addr < CSR_AW'(NUM_CSR))) begin
         coef_ff[csr_addr] <= csr_wdata;
      end
   end

   assign ce         = !f2_vld_ff || !q_full;
   assign req_tready = ce;
   assign q_push     = f2_vld_ff && !q_full;
   assign q_data     = f2_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            prp_in[r][k] = coef_of(coef_ff[2*r + k/2], 1'(k % 2))
                         * $signed(req_tdata[32*k +: 32]);
            prn_in[r][k] = coef_of(coef_ff[2*r + k/2], 1'(k % 2))
                         * $signed(req_tdata[96 + 32*k +: 32]);
         end
      end
   end

   always_comb begin
      logic signed [49:0] sp;
      logic signed [49:0] sn;
      f2_in     = f2_ff;
      f2_in.col = col_ff;
      for (int r = 0; r < 3; r++) begin
         sp = 50'(rnd_q16(prp_ff[r][0])) + 50'(rnd_q16(prp_ff[r][1]))
            + 50'(rnd_q16(prp_ff[r][2])) + 50'(tr_ff[r]);
         sn = 50'(rnd_q16(prn_ff[r][0])) + 50'(rnd_q16(prn_ff[r][1]))
            + 50'(rnd_q16(prn_ff[r][2]));
         f2_in.pos[r] = sat32(sp);
         f2_in.nrm[r] = sat32(sn);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else if (ce) begin
         f1_vld_ff <= req_tvalid;
         f2_vld_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         prp_ff <= prp_in;
         prn_ff <= prn_in;
         for (int r = 0; r < 3; r++) tr_ff[r] <= coef_of(coef_ff[2*r + 1], 1'b1);
         col_ff <= req_tdata[287:192];
         f2_ff  <= f2_in;
      end
   end

endmodule
`default_nettype wire

/* sv/vtn_queue.sv */
// Small queue between the front and the back.
`default_nettype none
module vtn_queue
   import vtn_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire xfm_type din,
   output logic         full,
   input  wire logic    pop,
   output xfm_type      dout,
   output logic         empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   xfm_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ff;
   logic [PW-1:0] rd_ff;
   logic [CW-1:0] cnt_ff;

   assign full  = cnt_ff == CW'(DEPTH);
   assign empty = cnt_ff == '0;
   assign dout  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
         if (pop)  rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
         if (push && !pop) cnt_ff <= cnt_ff + CW'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= din;
   end

endmodule
`default_nettype wire

/* sv/vtn_back.sv */
// Back: normal renormalization pipeline (scale, squares, sqrt, divide) and output register.
`default_nettype none
module vtn_back
   import vtn_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   output logic                  q_pop,
   input  wire xfm_type          q_data,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata
);

   localparam int SQ  = 32;
   localparam int DV  = 17;
   localparam int NST = 4 + SQ + DV + 1;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] col;
      logic [2:0]       neg;
      logic             zero;
   } side_type;

   logic [NST-1:0] vld_ff;
   logic           ce;

   logic [2:0][31:0] mag_a_ff, mag_a_in;
   side_type         side_a_ff, side_a_in;
   logic [2:0][31:0] nm_b_ff, nm_b_in;
   side_type         side_b_ff;
   logic [2:0][63:0] sq_c_ff, sq_c_in;
   logic [2:0][31:0] nm_c_ff;
   side_type         side_c_ff;
   logic [63:0]      sum_d_ff;
   logic [2:0][31:0] nm_d_ff;
   side_type         side_d_ff;

   logic [63:0]      srem_ff  [SQ];
   logic [31:0]      sroot_ff [SQ];
   logic [2:0][31:0] snm_ff   [SQ];
   side_type         sside_ff [SQ];

   logic [2:0][48:0] drem_ff [DV];
   logic [2:0][16:0] dq_ff   [DV];
   logic [31:0]      dlen_ff [DV];
   side_type         dside_ff [DV];

   logic [RSP_W-1:0] out_ff, out_in;

   assign ce         = !vld_ff[NST-1] || rsp_tready;
   assign q_pop      = ce && !q_empty;
   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tdata  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (ce) vld_ff <= {vld_ff[NST-2:0], q_pop};
   end

   // magnitudes and signs
   always_comb begin
      side_a_in.pos = q_data.pos;
      side_a_in.col = q_data.col;
      for (int i = 0; i < 3; i++) begin
         side_a_in.neg[i] = q_data.nrm[i][31];
         mag_a_in[i] = q_data.nrm[i][31] ? (~q_data.nrm[i] + 32'd1) : q_data.nrm[i];
      end
      side_a_in.zero = (mag_a_in[0] == '0) && (mag_a_in[1] == '0) && (mag_a_in[2] == '0);
   end

   // common left shift so the largest magnitude reaches bit 30 (none if it is already at bit 30 or 31)
   always_comb begin
      logic [31:0] mx;
      logic [4:0]  sh;
      mx = (mag_a_ff[0] > mag_a_ff[1]) ? mag_a_ff[0] : mag_a_ff[1];
      mx = (mx > mag_a_ff[2]) ? mx : mag_a_ff[2];
      sh = '0;
      if (mx[31:30] == 2'b00) begin
         for (int b = 0; b < 30; b++) begin
            if (mx[b]) sh = 5'(30 - b);
         end
      end
      for (int i = 0; i < 3; i++) nm_b_in[i] = mag_a_ff[i] << sh;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) sq_c_in[i] = nm_b_ff[i] * nm_b_ff[i];
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         mag_a_ff  <= mag_a_in;
         side_a_ff <= side_a_in;
         nm_b_ff   <= nm_b_in;
         side_b_ff <= side_a_ff;
         sq_c_ff   <= sq_c_in;
         nm_c_ff   <= nm_b_ff;
         side_c_ff <= side_b_ff;
         sum_d_ff  <= sq_c_ff[0] + sq_c_ff[1] + sq_c_ff[2];
         nm_d_ff   <= nm_c_ff;
         side_d_ff <= side_c_ff;
      end
   end

   // integer square root, one result bit per stage
   for (genvar j = 0; j < SQ; j++) begin : g_sqrt
      localparam int B = SQ - 1 - j;
      logic [63:0]      rem_p;
      logic [31:0]      root_p;
      logic [2:0][31:0] nm_p;
      side_type         side_p;
      logic [63:0]      trial;

      if (j == 0) begin : g_first
         assign rem_p  = sum_d_ff;
         assign root_p = '0;
         assign nm_p   = nm_d_ff;
         assign side_p = side_d_ff;
      end else begin : g_next
         assign rem_p  = srem_ff[j-1];
         assign root_p = sroot_ff[j-1];
         assign nm_p   = snm_ff[j-1];
         assign side_p = sside_ff[j-1];
      end

      assign trial = (64'(root_p) << (B + 1)) | (64'd1 << (2 * B));

      always_ff @(posedge clock) begin
         if (ce) begin
            if (rem_p >= trial) begin
               srem_ff[j]  <= rem_p - trial;
               sroot_ff[j] <= root_p | (32'd1 << B);
            end else begin
               srem_ff[j]  <= rem_p;
               sroot_ff[j] <= root_p;
            end
            snm_ff[j]   <= nm_p;
            sside_ff[j] <= side_p;
         end
      end
   end

   // rounded divide of each scaled magnitude by the length, one quotient bit per stage
   for (genvar j = 0; j < DV; j++) begin : g_div
      localparam int B = DV - 1 - j;
      logic [2:0][48:0] rem_p;
      logic [2:0][16:0] q_p;
      logic [31:0]      len_p;
      side_type         side_p;
      logic [48:0]      dsr;

      if (j == 0) begin : g_first
         assign len_p  = sroot_ff[SQ-1];
         assign side_p = sside_ff[SQ-1];
         for (genvar i = 0; i < 3; i++) begin : g_num
            assign rem_p[i] = (49'(snm_ff[SQ-1][i]) << 16) + 49'(sroot_ff[SQ-1] >> 1);
            assign q_p[i]   = '0;
         end
      end else begin : g_next
         assign rem_p  = drem_ff[j-1];
         assign q_p    = dq_ff[j-1];
         assign len_p  = dlen_ff[j-1];
         assign side_p = dside_ff[j-1];
      end

      assign dsr = 49'(len_p) << B;

      always_ff @(posedge clock) begin
         if (ce) begin
            for (int i = 0; i < 3; i++) begin
               if (rem_p[i] >= dsr) begin
                  drem_ff[j][i] <= rem_p[i] - dsr;
                  dq_ff[j][i]   <= q_p[i] | (17'd1 << B);
               end else begin
                  drem_ff[j][i] <= rem_p[i];
                  dq_ff[j][i]   <= q_p[i];
               end
            end
            dlen_ff[j]  <= len_p;
            dside_ff[j] <= side_p;
         end
      end
   end

   // clamp, sign, zero-normal override, pack
   always_comb begin
      logic [16:0]            q;
      logic [2:0][NRM_W-1:0]  un;
      side_type               sd;
      sd = dside_ff[DV-1];
      for (int i = 0; i < 3; i++) begin
         q = (dq_ff[DV-1][i] > ONE_Q16) ? ONE_Q16 : dq_ff[DV-1][i];
         un[i] = sd.neg[i] ? (NRM_W'(0) - NRM_W'(q)) : NRM_W'(q);
      end
      if (sd.zero) begin
         un[0] = '0;
         un[1] = '0;
         un[2] = NRM_W'(ONE_Q16);
      end
      out_in = {2'b00, sd.col, un, sd.pos};
   end

   always_ff @(posedge clock) begin
      if (ce) out_ff <= out_in;
   end

endmodule
`default_nettype wire

/* sv/vertex_transform_normalize.sv */
// Throughput: one vertex per cycle when nothing stalls; every stage is fully pipelined, the sqrt
//   (32 stages, one root bit each) and the three dividers (17 stages) included.
// Front (2 stages) and back (54 stages) stall independently across a small queue.
// Reset: synchronous, active high; clears all valid flags and queue pointers and
//   loads the identity matrix; datapath registers are not reset.
`default_nettype none
module vertex_transform_normalize
   import vtn_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // config write port, index 0..5 in register list order
   input  wire logic              csr_wen,
   input  wire logic [CSR_AW-1:0] csr_addr,
   input  wire logic [CSR_DW-1:0] csr_wdata,
   // vertex in
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // low to high: pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, col_r, col_g, col_b (32 each)
   input  wire logic [REQ_W-1:0]  req_tdata,
   // vertex out
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // low to high: out_pos_x/y/z (32 each), out_nrm_x/y/z (18 each),
   //   out_col_r/g/b (32 each), 2 zero pad bits
   output logic [RSP_W-1:0]       rsp_tdata
);

   // front -> queue
   logic    q_push;
   logic    q_full;
   xfm_type q_in;
   // queue -> back
   logic    q_pop;
   logic    q_empty;
   xfm_type q_out;

   // products, rounding and saturated sums for both position and normal
   vtn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_in)
   );

   // decouples the short front from the long back pipeline
   vtn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_in),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_out),
      .empty (q_empty)
   );

   // unit normal and output register
   vtn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_data     (q_out),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

/* sv/vtn_checker.sv */
// Port-level checker for the vertex transform, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module vtn_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [247:0] rsp_tdata
);

   `VTN_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `VTN_ASSERT(a_pad_zero, clock, reset, rsp_tvalid |-> rsp_tdata[247:246] == 2'b00)
   `VTN_ASSERT(a_nrm_range, clock, reset, rsp_tvalid |-> ($signed(rsp_tdata[113:96]) <= 18'sd65536 && $signed(rsp_tdata[113:96]) >= -18'sd65536 && $signed(rsp_tdata[149:132]) <= 18'sd65536 && $signed(rsp_tdata[149:132]) >= -18'sd65536))
   `VTN_ASSERT_ALWAYS(a_idle_after_reset, clock, $fell(reset) |-> !rsp_tvalid)

endmodule

bind vertex_transform_normalize vtn_checker u_vtn_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
